/* hdl/ssob_pkg.sv */
// Shared types and constants for the scanline span occlusion buffer.
// No dependencies; used by ssob_ctrl, ssob_dp and the top level.
`timescale 1ns / 1ps

package ssob_pkg;

  localparam int FUNC_W   = 2;
  localparam int Y_W      = 10;
  localparam int X_W      = 11;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 1;

  // coverage storage word, one bit per pixel column
  localparam int WORD_W   = 64;
  localparam int BIT_W    = $clog2(WORD_W);

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_W-1:0] VIEW_RESET = 11'd1024;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_TEST  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DRAW  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 1'd1;

  typedef struct packed {
    logic load;   // take the input word
    logic rd;     // read coverage word k, advance k
    logic clr;    // zero one coverage word of the sweep
    logic push;   // move result into the output register
  } ssob_cmd_t;

  typedef struct packed {
    logic in_clear;   // offered word is a clear
    logic in_act;     // offered word touches at least one active pixel
    logic last_word;  // k is the last word of the span
    logic clr_last;   // sweep is at the last address
    logic out_free;   // output register can take a result
  } ssob_sts_t;

endpackage

/* hdl/ssob_ctrl.sv */
// Sequencer for the occlusion buffer: init sweep, span scan, clear, result.
// Depends on ssob_pkg for the command and status structs.
`timescale 1ns / 1ps

module ssob_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ssob_pkg::ssob_sts_t  sts_i,
  output ssob_pkg::ssob_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CLEAR,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    cmd_o.load = accept;
    cmd_o.rd   = (state_q == ST_SCAN);
    cmd_o.clr  = (state_q == ST_INIT) || (state_q == ST_CLEAR);
    cmd_o.push = (state_q == ST_FINISH) && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          priority if (sts_i.in_clear) state_d = ST_CLEAR;
          else if (sts_i.in_act)       state_d = ST_SCAN;
          else                         state_d = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (sts_i.last_word) state_d = ST_DRAIN;
      end
      // last read word is merged this cycle
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/ssob_dp.sv */
// Datapath: config registers, item registers, coverage memory with
// read-modify-write stage, clear sweep counter and output register.
// Depends on ssob_pkg.
`timescale 1ns / 1ps

module ssob_dp #(
  parameter int MAX_WIDTH  = ssob_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ssob_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [ssob_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ssob_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic [ssob_pkg::FUNC_W-1:0]       func_i,
  input  logic [ssob_pkg::Y_W-1:0]          line_y_i,
  input  logic [ssob_pkg::X_W-1:0]          span_start_i,
  input  logic [ssob_pkg::X_W-1:0]          span_end_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic                              visible_o,
  input  ssob_pkg::ssob_cmd_t               cmd_i,
  output ssob_pkg::ssob_sts_t               sts_o
);

  localparam int WORD_W = ssob_pkg::WORD_W;
  localparam int BIT_W  = ssob_pkg::BIT_W;
  localparam int WORDS  = (MAX_WIDTH + WORD_W - 1) / WORD_W;
  localparam int KW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = ROW_W + KW;
  localparam int DEPTH  = MAX_HEIGHT * (2 ** KW);
  localparam int XW     = ($clog2(MAX_WIDTH + 1) > ssob_pkg::X_W) ?
                          $clog2(MAX_WIDTH + 1) : ssob_pkg::X_W;
  localparam int HW     = ($clog2(MAX_HEIGHT + 1) > ssob_pkg::CFG_W) ?
                          $clog2(MAX_HEIGHT + 1) : ssob_pkg::CFG_W;

  // config
  logic [ssob_pkg::CFG_W-1:0] view_width_q, view_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_width_q  <= ssob_pkg::VIEW_RESET;
      view_height_q <= ssob_pkg::VIEW_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ssob_pkg::REG_VIEW_WIDTH:  view_width_q  <= cfg_data_i;
        ssob_pkg::REG_VIEW_HEIGHT: view_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective bounds and span check on the offered word
  logic [XW-1:0]     w_eff, x0_ext, x1_ext, e_eff, e_m1;
  logic [HW-1:0]     h_eff, y_ext;
  logic              is_span;

  always_comb begin
    w_eff  = (XW'(view_width_q) < XW'(MAX_WIDTH)) ? XW'(view_width_q) : XW'(MAX_WIDTH);
    h_eff  = (HW'(view_height_q) < HW'(MAX_HEIGHT)) ? HW'(view_height_q) : HW'(MAX_HEIGHT);
    x0_ext = XW'(span_start_i);
    x1_ext = XW'(span_end_i);
    y_ext  = HW'(line_y_i);
    e_eff  = (x1_ext < w_eff) ? x1_ext : w_eff;
    e_m1   = e_eff - XW'(1);
    is_span = (func_i == ssob_pkg::FUNC_TEST) || (func_i == ssob_pkg::FUNC_DRAW);
  end

  // item registers
  logic               draw_q;
  logic [ROW_W-1:0]   row_q;
  logic [KW-1:0]      k_first_q, k_last_q, k_q, rd_k_q;
  logic [BIT_W-1:0]   lo_q, hi_m1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      draw_q    <= (func_i == ssob_pkg::FUNC_DRAW);
      row_q     <= ROW_W'(line_y_i);
      k_first_q <= KW'(x0_ext >> BIT_W);
      k_last_q  <= KW'(e_m1 >> BIT_W);
      k_q       <= KW'(x0_ext >> BIT_W);
      lo_q      <= x0_ext[BIT_W-1:0];
      hi_m1_q   <= e_m1[BIT_W-1:0];
    end else if (cmd_i.rd) begin
      k_q <= k_q + KW'(1);
    end
    if (cmd_i.rd) rd_k_q <= k_q;
  end

  // coverage memory: read one word per cycle, write back one stage later
  logic [WORD_W-1:0]  mem_q [DEPTH];
  logic [WORD_W-1:0]  rdata_q, mask, head_m, tail_m;
  logic               rd_vld_q;
  logic [ADDR_W-1:0]  clr_addr_q;
  logic               wr_en;

  always_comb begin
    head_m = (rd_k_q == k_first_q) ? ({WORD_W{1'b1}} << lo_q) : {WORD_W{1'b1}};
    tail_m = (rd_k_q == k_last_q) ? ({WORD_W{1'b1}} >> (~hi_m1_q)) : {WORD_W{1'b1}};
    mask   = head_m & tail_m;
    wr_en  = rd_vld_q && draw_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem_q[clr_addr_q] <= '0;
    end else if (wr_en) begin
      mem_q[{row_q, rd_k_q}] <= rdata_q | mask;
    end
    if (cmd_i.rd) rdata_q <= mem_q[{row_q, k_q}];
  end

  logic vis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      clr_addr_q <= '0;
      vis_q      <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd;
      if (cmd_i.load) begin
        clr_addr_q <= '0;
      end else if (cmd_i.clr) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
      end
      if (cmd_i.load) begin
        vis_q <= 1'b0;
      end else if (rd_vld_q && ((rdata_q & mask) != mask)) begin
        vis_q <= 1'b1;
      end
    end
  end

  // output register
  logic out_valid_q, visible_q;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) visible_q <= vis_q;
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;

  always_comb begin
    sts_o.in_clear  = (func_i == ssob_pkg::FUNC_CLEAR);
    sts_o.in_act    = is_span && (y_ext < h_eff) && (e_eff > x0_ext);
    sts_o.last_word = (k_q == k_last_q);
    sts_o.clr_last  = (clr_addr_q == ADDR_W'(DEPTH - 1));
    sts_o.out_free  = out_free;
  end

endmodule

/* hdl/scanline_span_occlusion_buffer_unit.sv */
// Span occlusion buffer: a span is scanned word by word, set by the
// one-word-per-cycle read-modify-write on the coverage memory (a draw writes
// the merged word back, a test only reads); one item is in work at a time.
// A clear zeroes all MAX_HEIGHT * 2^KW memory words, KW being the word index
// width (16384 words by default). After reset the same sweep zeroes the memory
// before the first word is taken; config writes are taken at any time.
`timescale 1ns / 1ps

module scanline_span_occlusion_buffer_unit #(
  parameter int MAX_WIDTH  = ssob_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ssob_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ssob_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ssob_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ssob_pkg::FUNC_W-1:0]       func_i,
  input  logic [ssob_pkg::Y_W-1:0]          line_y_i,
  input  logic [ssob_pkg::X_W-1:0]          span_start_i,
  input  logic [ssob_pkg::X_W-1:0]          span_end_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              visible_o
);

  ssob_pkg::ssob_cmd_t cmd;
  ssob_pkg::ssob_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ssob_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ssob_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .func_i       (func_i),
    .line_y_i     (line_y_i),
    .span_start_i (span_start_i),
    .span_end_i   (span_end_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .visible_o    (visible_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule
